[hdl/recorder_frame_stream_deframer_top_defines.svh]
// Assertion macros shared by the checker of the recorder frame stream deframer.
`ifndef RECORDER_FRAME_STREAM_DEFRAMER_TOP_DEFINES_SVH
`define RECORDER_FRAME_STREAM_DEFRAMER_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RFSD_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RFSD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/rfsd_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package rfsd_pkg;

    localparam int MAX_CHANNELS_DEF = 8;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_CHAN_COUNT   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REGION_WORDS = 1'd1;

    // A control frame is four words long; its result comes with the last one.
    localparam int CTRL_WORDS = 4;
    localparam int CTRL_LAST  = CTRL_WORDS - 1;

    // Control frame types, taken from the first word of the frame.
    localparam logic [3:0] CTRL_UNKNOWN = 4'd0;
    localparam logic [3:0] CTRL_TIME    = 4'd1;
    localparam logic [3:0] CTRL_VHUM    = 4'd3;
    localparam logic [3:0] CTRL_TEMP    = 4'd5;
    localparam logic [3:0] CTRL_LOST    = 4'd7;
    localparam logic [3:0] CTRL_CHECK   = 4'd9;
    localparam logic [3:0] CTRL_REBOOT  = 4'd11;
    localparam logic [3:0] CTRL_END     = 4'd13;
    localparam logic [3:0] CTRL_FNUM    = 4'd15;

    // Result kinds.
    localparam logic [3:0] KIND_SAMPLE = 4'd0;
    localparam logic [3:0] KIND_TIME   = 4'd1;
    localparam logic [3:0] KIND_VHUM   = 4'd2;
    localparam logic [3:0] KIND_TEMP   = 4'd3;
    localparam logic [3:0] KIND_LOST   = 4'd4;
    localparam logic [3:0] KIND_CHECK  = 4'd5;
    localparam logic [3:0] KIND_REBOOT = 4'd6;
    localparam logic [3:0] KIND_END    = 4'd7;
    localparam logic [3:0] KIND_FNUM   = 4'd8;

    typedef struct packed {
        logic [31:0] data_word;
        logic        region_start;
    } t_in;

    typedef struct packed {
        logic [3:0]         kind;
        logic [2:0]         channel;
        logic signed [31:0] sample_value;
        logic [63:0]        sample_seq;
        logic [31:0]        value_a;
        logic [15:0]        value_b;
        logic               discontinuity;
        logic               region_end;
    } t_out;

endpackage

`default_nettype wire

[hdl/recorder_frame_stream_deframer_top.sv]
// A result is registered into the result queue when the word that closes it is transferred.
// Throughput: one word per cycle while o_in_ready is high; words that close no result give none.
// A two-entry result queue lets a word be taken while a result still waits; o_in_ready
// drops only when both entries are full.
// Reset (synchronous, active low) clears position, frame progress, sample number, done flag,
// the queue, and sets the channel count to 1 and region_words to 0.
`timescale 1ns / 1ps
`default_nettype none

module recorder_frame_stream_deframer_top
    import rfsd_pkg::*;
#(
    parameter int MAX_CHANNELS = MAX_CHANNELS_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire t_in                  i_in_data,
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output t_out                      o_out_data,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [31:0]          i_cfg_data
);

    // The frame counter must hold both the last channel and the last control word.
    localparam int WIF_W = (MAX_CHANNELS > CTRL_WORDS) ? $clog2(MAX_CHANNELS) : 2;
    localparam int EFF_W = $clog2(MAX_CHANNELS + 1);
    localparam int CMP_W = (WIF_W + 1 > EFF_W) ? WIF_W + 1 : EFF_W;

    logic [3:0]       r_chan_count;
    logic [31:0]      r_region_words;
    logic [31:0]      r_pos, n_pos;
    logic [WIF_W-1:0] r_wif, n_wif;
    logic             r_is_ctl, n_is_ctl;
    logic [3:0]       r_ctl_type, n_ctl_type;
    logic [31:0]      r_cw0, n_cw0;
    logic [31:0]      r_cw1, n_cw1;
    logic [63:0]      r_rsn, n_rsn;
    logic             r_done, n_done;

    t_out             r_q [2];
    logic             r_q_wr;
    logic             r_q_rd;
    logic [1:0]       r_q_cnt;

    logic [EFF_W-1:0] eff_ch;
    logic             take;
    logic             pop;
    logic             has_res;
    t_out             res;

    assign take        = i_in_valid && o_in_ready;
    assign pop         = o_out_valid && i_out_ready;
    assign o_in_ready  = (r_q_cnt != 2'd2);
    assign o_out_valid = (r_q_cnt != 2'd0);
    assign o_out_data  = r_q[r_q_rd];

    always_comb begin
        if (r_chan_count == 4'd0) begin
            eff_ch = EFF_W'(1);
        end else if (32'(r_chan_count) > MAX_CHANNELS) begin
            eff_ch = EFF_W'(MAX_CHANNELS);
        end else begin
            eff_ch = EFF_W'(r_chan_count);
        end
    end

    always_comb begin
        logic [31:0]      word;
        logic [31:0]      s_pos;
        logic [WIF_W-1:0] s_wif;
        logic [63:0]      s_rsn;
        logic             s_done;
        logic             first;
        logic [32:0]      frame_len;
        logic             over;
        logic             cur_ctl;
        logic [3:0]       cur_type;
        logic [31:0]      pos_inc;
        logic [CMP_W-1:0] k_inc;
        logic [31:0]      lost;
        logic [63:0]      fnum;
        logic             complete;

        word     = i_in_data.data_word;
        s_pos    = i_in_data.region_start ? 32'd0 : r_pos;
        s_wif    = i_in_data.region_start ? '0 : r_wif;
        s_rsn    = i_in_data.region_start ? 64'd0 : r_rsn;
        s_done   = i_in_data.region_start ? 1'b0 : r_done;

        first     = (s_wif == '0);
        frame_len = word[0] ? 33'(CTRL_WORDS) : 33'(eff_ch);
        over      = first && (({1'b0, s_pos} + frame_len) > {1'b0, r_region_words});
        cur_ctl   = first ? word[0] : r_is_ctl;
        if (!first) begin
            cur_type = r_ctl_type;
        end else if (word < 32'd16) begin
            cur_type = word[3:0];
        end else begin
            cur_type = CTRL_UNKNOWN;
        end
        pos_inc  = s_pos + 32'd1;
        k_inc    = CMP_W'(s_wif) + CMP_W'(1);
        lost     = {r_cw1[15:0], word[31:16]};
        fnum     = {r_cw0, r_cw1};
        complete = 1'b0;

        n_pos      = r_pos;
        n_wif      = r_wif;
        n_is_ctl   = r_is_ctl;
        n_ctl_type = r_ctl_type;
        n_cw0      = r_cw0;
        n_cw1      = r_cw1;
        n_rsn      = r_rsn;
        n_done     = r_done;
        res        = '0;
        has_res    = 1'b0;

        if (take) begin
            n_pos  = s_pos;
            n_wif  = s_wif;
            n_rsn  = s_rsn;
            n_done = s_done;
            if (!s_done) begin
                if (over) begin
                    // The frame would run past the region: close the region here.
                    res.kind          = KIND_END;
                    res.sample_seq    = s_rsn;
                    res.region_end    = 1'b1;
                    has_res           = 1'b1;
                    n_done            = 1'b1;
                end else begin
                    n_is_ctl   = cur_ctl;
                    n_ctl_type = cur_type;
                    n_pos      = pos_inc;
                    if (cur_ctl) begin
                        if (32'(s_wif) < CTRL_LAST) begin
                            if (s_wif == WIF_W'(1)) begin
                                n_cw0 = word;
                            end
                            if (s_wif == WIF_W'(2)) begin
                                n_cw1 = word;
                            end
                            n_wif = WIF_W'(k_inc);
                        end else begin
                            n_wif    = '0;
                            complete = 1'b1;
                            has_res  = 1'b1;
                            case (cur_type)
                                CTRL_TIME: begin
                                    res.kind    = KIND_TIME;
                                    res.value_a = r_cw0;
                                end
                                CTRL_VHUM: begin
                                    res.kind    = KIND_VHUM;
                                    res.value_a = {{16{r_cw0[31]}}, r_cw0[31:16]};
                                    res.value_b = r_cw0[15:0];
                                end
                                CTRL_TEMP: begin
                                    res.kind    = KIND_TEMP;
                                    res.value_a = {{16{r_cw0[31]}}, r_cw0[31:16]};
                                end
                                CTRL_LOST: begin
                                    res.kind          = KIND_LOST;
                                    res.value_a       = lost;
                                    res.discontinuity = 1'b1;
                                    n_rsn             = s_rsn + 64'(lost);
                                end
                                CTRL_CHECK: begin
                                    res.kind    = KIND_CHECK;
                                    res.value_a = r_cw0;
                                    res.value_b = r_cw1[31:16];
                                end
                                CTRL_REBOOT: begin
                                    res.kind = KIND_REBOOT;
                                end
                                CTRL_END: begin
                                    res.kind       = KIND_END;
                                    res.region_end = 1'b1;
                                    n_done         = 1'b1;
                                end
                                CTRL_FNUM: begin
                                    res.kind = KIND_FNUM;
                                    if (fnum != s_rsn) begin
                                        res.discontinuity = 1'b1;
                                        n_rsn             = fnum;
                                    end
                                end
                                default: begin
                                    has_res = 1'b0;
                                end
                            endcase
                            res.sample_seq = n_rsn;
                        end
                    end else begin
                        res.kind          = KIND_SAMPLE;
                        res.channel       = 3'(s_wif);
                        res.sample_value  = signed'(word);
                        res.sample_seq    = s_rsn;
                        has_res           = 1'b1;
                        // A channel count lowered mid-frame also ends the frame.
                        if (k_inc >= CMP_W'(eff_ch)) begin
                            n_wif    = '0;
                            n_rsn    = s_rsn + 64'd1;
                            complete = 1'b1;
                        end else begin
                            n_wif = WIF_W'(k_inc);
                        end
                    end
                    if (complete && !n_done && (pos_inc >= r_region_words)) begin
                        // A skipped control frame that uses up the region still
                        // needs an end result of its own.
                        if (!has_res) begin
                            res               = '0;
                            res.kind          = KIND_END;
                            res.sample_seq    = n_rsn;
                            has_res           = 1'b1;
                        end
                        res.region_end = 1'b1;
                        n_done         = 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chan_count    <= 4'd1;
            r_region_words  <= 32'd0;
            r_pos           <= 32'd0;
            r_wif           <= '0;
            r_is_ctl        <= 1'b0;
            r_ctl_type      <= CTRL_UNKNOWN;
            r_cw0           <= 32'd0;
            r_cw1           <= 32'd0;
            r_rsn           <= 64'd0;
            r_done          <= 1'b0;
            r_q_wr          <= 1'b0;
            r_q_rd          <= 1'b0;
            r_q_cnt         <= 2'd0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_CHAN_COUNT:   r_chan_count   <= i_cfg_data[3:0];
                    CFG_REGION_WORDS: r_region_words <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            r_pos      <= n_pos;
            r_wif      <= n_wif;
            r_is_ctl   <= n_is_ctl;
            r_ctl_type <= n_ctl_type;
            r_cw0      <= n_cw0;
            r_cw1      <= n_cw1;
            r_rsn      <= n_rsn;
            r_done     <= n_done;
            if (has_res) begin
                r_q_wr <= ~r_q_wr;
            end
            if (pop) begin
                r_q_rd <= ~r_q_rd;
            end
            case ({has_res, pop})
                2'b10:   r_q_cnt <= r_q_cnt + 2'd1;
                2'b01:   r_q_cnt <= r_q_cnt - 2'd1;
                default: r_q_cnt <= r_q_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (has_res) begin
            r_q[r_q_wr] <= res;
        end
    end

endmodule

`default_nettype wire

[hdl/rfsd_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
`include "recorder_frame_stream_deframer_top_defines.svh"

module rfsd_checker
    import rfsd_pkg::*;
(
    input wire logic                 i_clk,
    input wire logic                 i_rst_n,
    input wire logic                 i_in_valid,
    input wire logic                 o_in_ready,
    input wire logic                 o_out_valid,
    input wire logic                 i_out_ready,
    input wire t_out                 o_out_data
);

    logic in_xfer;
    logic out_stall;

    assign in_xfer   = i_in_valid && o_in_ready;
    assign out_stall = o_out_valid && !i_out_ready;

    `RFSD_ASSERT_NEXT(a_out_valid_holds, i_clk, i_rst_n, out_stall, o_out_valid, "result dropped while stalled")
    `RFSD_ASSERT_NEXT(a_out_data_holds, i_clk, i_rst_n, out_stall, $stable(o_out_data), "result changed while stalled")
    `RFSD_ASSERT_IMPL(a_result_has_word, i_clk, i_rst_n, $rose(o_out_valid), $past(in_xfer), "result without a word transfer")
    `RFSD_ASSERT_IMPL(a_end_closes, i_clk, i_rst_n, o_out_valid && (o_out_data.kind == KIND_END), o_out_data.region_end, "end result without region_end")
    `RFSD_ASSERT_IMPL(a_lost_breaks, i_clk, i_rst_n, o_out_valid && (o_out_data.kind == KIND_LOST), o_out_data.discontinuity, "lost result without discontinuity")

endmodule

bind recorder_frame_stream_deframer_top rfsd_checker u_rfsd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);

`default_nettype wire

[bench/deframer_checker.sv]
`timescale 1ns / 1ps

module deframer_checker
    import rfsd_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    input  wire logic                 i_in_ready,
    input  wire t_in                  i_in_data,
    input  wire logic                 i_out_valid,
    input  wire logic                 i_out_ready,
    input  wire t_out                 i_out_data,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [31:0]          i_cfg_data,
    output int                        o_fail_count,
    output int                        o_pending
);

    // Register copies.
    logic [3:0]  chan_reg;
    logic [31:0] region_limit;

    // Deframer state as the block should hold it.
    logic [31:0] words_used;
    logic [2:0]  frame_word;
    logic        in_control;
    logic [3:0]  ctl_kind;
    logic [31:0] ctl_payload [2];
    logic [63:0] sample_count;
    logic        region_closed;

    t_out expected_results[$];

    initial o_fail_count = 0;

    function automatic int active_channels();
        if (chan_reg == 4'd0) return 1;
        if (chan_reg > MAX_CHANNELS_DEF) return MAX_CHANNELS_DEF;
        return int'(chan_reg);
    endfunction

    // Builds an end result and closes the region.
    function automatic t_out region_closing();
        t_out res;
        res = '0;
        res.kind = KIND_END;
        res.sample_seq = sample_count;
        res.region_end = 1'b1;
        region_closed = 1'b1;
        return res;
    endfunction

    task automatic deframe_word(input t_in item, output bit produced, output t_out res);
        logic [31:0] w;
        int          n;
        logic [2:0]  k;
        bit          complete;
        logic [31:0] lost;
        logic [63:0] fnum;
        logic [32:0] span;
        w = item.data_word;
        n = active_channels();
        produced = 1'b0;
        complete = 1'b0;
        res = '0;
        if (item.region_start) begin
            words_used = '0;
            frame_word = '0;
            sample_count = '0;
            region_closed = 1'b0;
        end
        if (region_closed) return;

        if (frame_word == 3'd0) begin
            span = {1'b0, words_used} + (w[0] ? 33'd4 : 33'(n));
            if (span > {1'b0, region_limit}) begin
                res = region_closing();
                produced = 1'b1;
                return;
            end
            in_control = w[0];
            ctl_kind = (w < 32'd16) ? w[3:0] : CTRL_UNKNOWN;
        end

        k = frame_word;
        words_used = words_used + 32'd1;

        if (in_control) begin
            if (int'(k) < CTRL_LAST) begin
                if (k >= 3'd1) ctl_payload[k - 3'd1] = w;
                frame_word = k + 3'd1;
                return;
            end
            frame_word = '0;
            complete = 1'b1;
            produced = 1'b1;
            case (ctl_kind)
                CTRL_TIME: begin
                    res.kind = KIND_TIME;
                    res.value_a = ctl_payload[0];
                end
                CTRL_VHUM: begin
                    res.kind = KIND_VHUM;
                    res.value_a = {{16{ctl_payload[0][31]}}, ctl_payload[0][31:16]};
                    res.value_b = ctl_payload[0][15:0];
                end
                CTRL_TEMP: begin
                    res.kind = KIND_TEMP;
                    res.value_a = {{16{ctl_payload[0][31]}}, ctl_payload[0][31:16]};
                end
                CTRL_LOST: begin
                    lost = {ctl_payload[1][15:0], w[31:16]};
                    sample_count = sample_count + {32'd0, lost};
                    res.kind = KIND_LOST;
                    res.value_a = lost;
                    res.discontinuity = 1'b1;
                end
                CTRL_CHECK: begin
                    res.kind = KIND_CHECK;
                    res.value_a = ctl_payload[0];
                    res.value_b = ctl_payload[1][31:16];
                end
                CTRL_REBOOT: res.kind = KIND_REBOOT;
                CTRL_END: begin
                    res.kind = KIND_END;
                    res.region_end = 1'b1;
                    region_closed = 1'b1;
                end
                CTRL_FNUM: begin
                    fnum = {ctl_payload[0], ctl_payload[1]};
                    if (fnum != sample_count) begin
                        res.discontinuity = 1'b1;
                        sample_count = fnum;
                    end
                    res.kind = KIND_FNUM;
                end
                default: produced = 1'b0;
            endcase
            res.sample_seq = sample_count;
        end else begin
            res.kind = KIND_SAMPLE;
            res.channel = k;
            res.sample_value = w;
            res.sample_seq = sample_count;
            produced = 1'b1;
            if (int'(k) + 1 >= n) begin
                frame_word = '0;
                sample_count = sample_count + 64'd1;
                complete = 1'b1;
            end else begin
                frame_word = k + 3'd1;
            end
        end

        // A frame that ends at or past the region size closes the region.
        if (complete && !region_closed && words_used >= region_limit) begin
            if (!produced) begin
                res = region_closing();
                produced = 1'b1;
            end else begin
                res.region_end = 1'b1;
                region_closed = 1'b1;
            end
        end
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
            o_fail_count++;
        end
    endtask

    always @(posedge i_clk) begin : watch
        bit   produced;
        t_out want;
        t_out got;
        if (!i_rst_n) begin
            chan_reg = 4'd1;
            region_limit = '0;
            words_used = '0;
            frame_word = '0;
            in_control = 1'b0;
            ctl_kind = CTRL_UNKNOWN;
            ctl_payload[0] = '0;
            ctl_payload[1] = '0;
            sample_count = '0;
            region_closed = 1'b0;
            expected_results.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_CHAN_COUNT:   chan_reg = i_cfg_data[3:0];
                    CFG_REGION_WORDS: region_limit = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_out_valid && i_out_ready) begin
                got = i_out_data;
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result transfer, kind %0d", $time, got.kind);
                    o_fail_count++;
                end else begin
                    want = expected_results.pop_front();
                    check_field("kind", 64'(want.kind), 64'(got.kind));
                    check_field("channel", 64'(want.channel), 64'(got.channel));
                    check_field("sample_value", 64'(want.sample_value),
                                64'(got.sample_value));
                    check_field("sample_seq", want.sample_seq, got.sample_seq);
                    check_field("value_a", 64'(want.value_a), 64'(got.value_a));
                    check_field("value_b", 64'(want.value_b), 64'(got.value_b));
                    check_field("discontinuity", 64'(want.discontinuity),
                                64'(got.discontinuity));
                    check_field("region_end", 64'(want.region_end), 64'(got.region_end));
                end
            end
            if (i_in_valid && i_in_ready) begin
                deframe_word(i_in_data, produced, want);
                if (produced) expected_results.push_back(want);
            end
        end
        o_pending <= expected_results.size();
    end

endmodule

[bench/tb.sv]
`timescale 1ns / 1ps

module tb;
    import rfsd_pkg::*;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    t_in                  in_data = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    t_out                 out_data;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_idx = CFG_CHAN_COUNT;
    logic [31:0]          cfg_data = '0;

    int fail_count;
    int pending;

    t_in word_queue[$];
    bit  steady = 1'b0;
    int  active_n = 1;
    int  words_sent = 0;

    // Settings walked through by the random part; later phases pick their own.
    logic [3:0]  phase_channels [8] = '{4'd1, 4'd2, 4'd8, 4'd0, 4'd15, 4'd3, 4'd9, 4'd4};
    logic [31:0] phase_limits [8] = '{32'd0, 32'd30, 32'd200, 32'd17, 32'd1000,
                                      32'hFFFF_FFFF, 32'd12, 32'd4};

    recorder_frame_stream_deframer_top i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data)
    );

    deframer_checker i_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_data   (out_data),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        forever #2 clk = ~clk;
    end

    initial begin
        #2_000_000;
        $display("tb failed");
        $finish;
    end

    // The word at the head of the queue is the one on the bus until its transfer.
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else if (!in_valid || in_ready) begin
            if (in_valid) void'(word_queue.pop_front());
            if (word_queue.size() != 0 && (steady || $urandom_range(99) >= 25)) begin
                in_valid <= 1'b1;
                in_data <= word_queue[0];
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk) begin
        out_ready <= steady || ($urandom_range(99) >= 25);
    end

    task automatic put_word(input logic [31:0] w, input bit start);
        t_in item;
        while (word_queue.size() >= 4) @(posedge clk);
        item.data_word = w;
        item.region_start = start;
        word_queue.push_back(item);
        words_sent++;
    endtask

    task automatic wait_idle();
        while (word_queue.size() != 0 || in_valid || pending != 0) @(posedge clk);
    endtask

    task automatic set_config(input logic [3:0] channels, input logic [31:0] limit);
        logic [31:0] filler;
        filler = $urandom;
        wait_idle();
        // A word that ends no result may still be in flight.
        repeat (4) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_idx <= CFG_CHAN_COUNT;
        cfg_data <= {filler[31:4], channels};
        @(posedge clk);
        cfg_idx <= CFG_REGION_WORDS;
        cfg_data <= limit;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (channels == 4'd0) active_n = 1;
        else if (channels > MAX_CHANNELS_DEF) active_n = MAX_CHANNELS_DEF;
        else active_n = int'(channels);
    endtask

    task automatic put_frame(input bit start);
        int unsigned pick;
        logic [31:0] head;
        logic [31:0] body [3];
        logic [3:0]  code;
        pick = $urandom_range(99);
        for (int i = 0; i < 3; i++) body[i] = $urandom;
        if (pick < 45) begin
            head = $urandom;
            if (pick < 10) head = head & 32'h0000_001E;
            head[0] = 1'b0;
            put_word(head, start);
            for (int i = 1; i < active_n; i++) put_word($urandom, 1'b0);
        end else begin
            case ($urandom_range(9))
                0: code = CTRL_TIME;
                1: code = CTRL_VHUM;
                2: code = CTRL_TEMP;
                3: code = CTRL_LOST;
                4: code = CTRL_CHECK;
                5: code = CTRL_REBOOT;
                6, 7: code = CTRL_FNUM;
                8: code = CTRL_UNKNOWN;
                default: code = ($urandom_range(2) == 0) ? CTRL_END : CTRL_REBOOT;
            endcase
            head = (code == CTRL_UNKNOWN) ? ($urandom | 32'h11) : {28'd0, code};
            // Small counts and numbers keep the sample number near its running value.
            if (code == CTRL_LOST && $urandom_range(3) != 0) begin
                body[1][15:0] = '0;
                body[2][31:16] = 16'($urandom_range(50));
            end
            if (code == CTRL_FNUM && $urandom_range(1) == 1) begin
                body[0] = '0;
                body[1] = $urandom_range(40);
            end
            put_word(head, start);
            for (int i = 0; i < 3; i++) put_word(body[i], 1'b0);
        end
    endtask

    task automatic put_region(input int frames);
        put_frame(1'b1);
        repeat (frames - 1) begin
            // Stray words break the frame alignment now and then.
            if ($urandom_range(99) < 8) put_word($urandom, $urandom_range(15) == 0);
            put_frame(1'b0);
        end
        repeat ($urandom_range(2)) put_word($urandom, 1'b0);
    endtask

    initial begin
        int phase_stop;
        logic [3:0]  channels;
        logic [31:0] limit;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        set_config(4'd2, 32'd1000);
        put_word(32'h8000_0000, 1'b1);
        put_word(32'h7FFF_FFFF, 1'b0);
        // Lost count of all ones carries the sample number past 32 bits.
        put_word({28'd0, CTRL_LOST}, 1'b0);
        put_word(32'h0, 1'b0);
        put_word(32'h0000_FFFF, 1'b0);
        put_word(32'hFFFF_0000, 1'b0);
        // Frame number equal to the running one: no break.
        put_word({28'd0, CTRL_FNUM}, 1'b0);
        put_word(32'h1, 1'b0);
        put_word(32'h0, 1'b0);
        put_word(32'h0, 1'b0);
        // Largest frame number, then a data frame makes the count wrap.
        put_word({28'd0, CTRL_FNUM}, 1'b0);
        put_word(32'hFFFF_FFFF, 1'b0);
        put_word(32'hFFFF_FFFF, 1'b0);
        put_word(32'h0, 1'b0);
        put_word(32'h0, 1'b0);
        put_word(32'hFFFF_FFFF, 1'b0);
        put_word(32'hFFFF_FFFF, 1'b0);
        put_word(32'h1234_5678, 1'b0);
        put_word(32'h0, 1'b0);
        put_word(32'h0, 1'b0);
        put_word({28'd0, CTRL_END}, 1'b0);
        put_word(32'hFFFF_FFFF, 1'b0);
        put_word(32'hFFFF_FFFF, 1'b0);
        put_word(32'hFFFF_FFFF, 1'b0);
        put_word(32'h1234_5678, 1'b0);

        for (int phase = 0; phase < 10; phase++) begin
            if (phase < 8) begin
                channels = phase_channels[phase];
                limit = phase_limits[phase];
            end else begin
                channels = 4'($urandom_range(15));
                limit = $urandom_range(120);
            end
            set_config(channels, limit);
            steady = (phase == 5);
            phase_stop = words_sent + 25;
            // An unknown frame that uses the region up exactly.
            if (phase == 7) begin
                put_word(32'h0000_0011, 1'b1);
                repeat (3) put_word($urandom, 1'b0);
            end
            if ($urandom_range(1) == 1) put_frame(1'b0);
            while (words_sent < phase_stop) put_region($urandom_range(1, 8));
            // Leave a data frame open so the next setting lands in its middle.
            if ($urandom_range(1) == 1) put_word($urandom & ~32'h1, 1'b0);
        end
        steady = 1'b0;

        wait_idle();
        repeat (10) @(posedge clk);
        if (fail_count == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end

endmodule
